// ===== design/lpd_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the length-prefixed packet deframer
// no dependencies

package lpd_pkg;

    // prefix layout: 16-bit header length, then 32-bit body length, big-endian
    localparam int PREFIX_BYTES   = 6;
    localparam int HDR_LEN_W      = 16;
    localparam int BODY_LEN_W     = 32;
    localparam int PREFIX_STORE_W = 8 * (PREFIX_BYTES - 1);
    localparam int PREFIX_CNT_W   = 3;

    // result queue between parser and output side
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // byte classification codes
    localparam logic [1:0] KIND_PREFIX = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_BODY   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    typedef struct packed {
        logic [1:0]            byte_kind;
        logic [7:0]            byte_out;
        logic                  header_end;
        logic                  packet_end;
        logic [HDR_LEN_W-1:0]  frame_header_len;
        logic [BODY_LEN_W-1:0] frame_body_len;
    } t_result;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

// ===== design/lpd_front.sv =====
`timescale 1ns / 1ps
// parser front end: tracks the packet section and tags each accepted byte
// depends on lpd_pkg

module lpd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [7:0]                        i_byte_in,
    input  logic [lpd_pkg::BODY_LEN_W-1:0]    i_max_total,
    output lpd_pkg::t_result                  o_result
);

    localparam logic [1:0] STG_PREFIX = 2'd0;
    localparam logic [1:0] STG_HEADER = 2'd1;
    localparam logic [1:0] STG_BODY   = 2'd2;

    localparam logic [lpd_pkg::PREFIX_CNT_W-1:0] LAST_PREFIX =
        lpd_pkg::PREFIX_CNT_W'(lpd_pkg::PREFIX_BYTES - 1);
    localparam int FULL_W = 8 * lpd_pkg::PREFIX_BYTES;

    logic [1:0]                              r_stage, n_stage;
    logic [lpd_pkg::PREFIX_CNT_W-1:0]        r_prefix_count, n_prefix_count;
    logic [lpd_pkg::PREFIX_STORE_W-1:0]      r_prefix_store, n_prefix_store;
    logic [lpd_pkg::HDR_LEN_W-1:0]           r_header_len, n_header_len;
    logic [lpd_pkg::BODY_LEN_W-1:0]          r_body_len, n_body_len;
    logic [lpd_pkg::HDR_LEN_W-1:0]           r_header_count, n_header_count;
    logic [lpd_pkg::BODY_LEN_W-1:0]          r_body_count, n_body_count;

    logic [FULL_W-1:0]                       prefix_full;
    logic [lpd_pkg::HDR_LEN_W-1:0]           dec_hlen;
    logic [lpd_pkg::BODY_LEN_W-1:0]          dec_blen;
    logic [lpd_pkg::BODY_LEN_W:0]            len_sum;
    logic                                    too_big;
    logic [lpd_pkg::HDR_LEN_W-1:0]           hc_inc;
    logic [lpd_pkg::BODY_LEN_W-1:0]          bc_inc;

    // assembled prefix including the current byte
    assign prefix_full = {r_prefix_store, i_byte_in};
    assign dec_hlen    = prefix_full[FULL_W-1 -: lpd_pkg::HDR_LEN_W];
    assign dec_blen    = prefix_full[lpd_pkg::BODY_LEN_W-1:0];

    // header or body alone over the limit also puts the sum over it
    assign len_sum = {{(lpd_pkg::BODY_LEN_W + 1 - lpd_pkg::HDR_LEN_W){1'b0}}, dec_hlen}
                   + {1'b0, dec_blen};
    assign too_big = (i_max_total != '0) && (len_sum > {1'b0, i_max_total});

    assign hc_inc = r_header_count + 1'b1;
    assign bc_inc = r_body_count + 1'b1;

    always_comb begin
        n_stage        = r_stage;
        n_prefix_count = r_prefix_count;
        n_prefix_store = r_prefix_store;
        n_header_len   = r_header_len;
        n_body_len     = r_body_len;
        n_header_count = r_header_count;
        n_body_count   = r_body_count;

        o_result                  = '0;
        o_result.byte_out         = i_byte_in;
        o_result.byte_kind        = lpd_pkg::KIND_PREFIX;

        unique case (r_stage)
            STG_HEADER: begin
                o_result.byte_kind = lpd_pkg::KIND_HEADER;
                n_header_count     = hc_inc;
                if (hc_inc == r_header_len) begin
                    o_result.header_end = 1'b1;
                    n_header_count      = '0;
                    if (r_body_len == '0) begin
                        o_result.packet_end = 1'b1;
                        n_stage             = STG_PREFIX;
                    end else begin
                        n_stage      = STG_BODY;
                        n_body_count = '0;
                    end
                end
            end
            STG_BODY: begin
                o_result.byte_kind = lpd_pkg::KIND_BODY;
                n_body_count       = bc_inc;
                if (bc_inc == r_body_len) begin
                    o_result.packet_end = 1'b1;
                    n_body_count        = '0;
                    n_stage             = STG_PREFIX;
                end
            end
            default: begin
                // prefix stage, unused code folds in here
                n_stage = STG_PREFIX;
                if (r_prefix_count < LAST_PREFIX) begin
                    n_prefix_store = prefix_full[lpd_pkg::PREFIX_STORE_W-1:0];
                    n_prefix_count = r_prefix_count + 1'b1;
                end else begin
                    o_result.frame_header_len = dec_hlen;
                    o_result.frame_body_len   = dec_blen;
                    n_prefix_store            = '0;
                    n_prefix_count            = '0;
                    n_header_count            = '0;
                    n_body_count              = '0;
                    if (too_big) begin
                        o_result.byte_kind = lpd_pkg::KIND_ERROR;
                        n_header_len       = '0;
                        n_body_len         = '0;
                    end else begin
                        n_header_len = dec_hlen;
                        n_body_len   = dec_blen;
                        if (dec_hlen != '0) begin
                            n_stage = STG_HEADER;
                        end else begin
                            o_result.header_end = 1'b1;
                            if (dec_blen != '0) begin
                                n_stage = STG_BODY;
                            end else begin
                                o_result.packet_end = 1'b1;
                            end
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage        <= STG_PREFIX;
            r_prefix_count <= '0;
            r_prefix_store <= '0;
            r_header_len   <= '0;
            r_body_len     <= '0;
            r_header_count <= '0;
            r_body_count   <= '0;
        end else if (i_accept) begin
            r_stage        <= n_stage;
            r_prefix_count <= n_prefix_count;
            r_prefix_store <= n_prefix_store;
            r_header_len   <= n_header_len;
            r_body_len     <= n_body_len;
            r_header_count <= n_header_count;
            r_body_count   <= n_body_count;
        end
    end

endmodule

// ===== design/lpd_result_queue.sv =====
`timescale 1ns / 1ps
// short result queue decoupling the parser from the output side
// depends on lpd_pkg

module lpd_result_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  lpd_pkg::t_result       i_wr_data,
    input  logic                   i_rd,
    output lpd_pkg::t_result       o_rd_data,
    output lpd_pkg::t_queue_status o_status
);

    lpd_pkg::t_result                r_mem [lpd_pkg::QUEUE_DEPTH];
    logic [lpd_pkg::QUEUE_AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [lpd_pkg::QUEUE_AW:0]      r_count, n_count;
    logic                            do_wr, do_rd;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (lpd_pkg::QUEUE_AW + 1)'(lpd_pkg::QUEUE_DEPTH));

    assign do_wr = i_wr && !o_status.full;
    assign do_rd = i_rd && !o_status.empty;

    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== design/length_prefixed_packet_deframer_unit.sv =====
`timescale 1ns / 1ps
// length-prefixed packet deframer, top level: limit register, parser, result queue
// each accepted byte is tagged combinationally and registered into the result queue
// throughput: one byte per cycle while the result queue is not full
// the four-entry result queue lets input continue while results wait to be popped
// reset: synchronous, active low; clears parser state, the queue and the size limit
// depends on lpd_pkg, lpd_front, lpd_result_queue

module length_prefixed_packet_deframer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request input side
    input  logic                               push,
    output logic                               full,
    input  logic [7:0]                         i_byte_in,
    // result side
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         o_byte_kind,
    output logic [7:0]                         o_byte_out,
    output logic                               o_header_end,
    output logic                               o_packet_end,
    output logic [lpd_pkg::HDR_LEN_W-1:0]      o_frame_header_len,
    output logic [lpd_pkg::BODY_LEN_W-1:0]     o_frame_body_len,
    // size limit register
    input  logic                               i_cfg_we,
    input  logic [lpd_pkg::BODY_LEN_W-1:0]     i_cfg_wdata
);

    logic [lpd_pkg::BODY_LEN_W-1:0] r_max_total;
    logic                           accept;
    lpd_pkg::t_result               front_result;
    lpd_pkg::t_result               head_result;
    lpd_pkg::t_queue_status         q_status;

    // limit on header plus body length, zero turns the check off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_total <= '0;
        end else if (i_cfg_we) begin
            r_max_total <= i_cfg_wdata;
        end
    end

    // a request is taken whenever the queue has room
    assign full   = q_status.full;
    assign empty  = q_status.empty;
    assign accept = push && !q_status.full;

    // front: section tracking and tagging of each byte
    lpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte_in   (i_byte_in),
        .i_max_total (r_max_total),
        .o_result    (front_result)
    );

    // back: results wait here until popped
    lpd_result_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_data (front_result),
        .i_rd      (pop),
        .o_rd_data (head_result),
        .o_status  (q_status)
    );

    assign o_byte_kind        = head_result.byte_kind;
    assign o_byte_out         = head_result.byte_out;
    assign o_header_end       = head_result.header_end;
    assign o_packet_end       = head_result.packet_end;
    assign o_frame_header_len = head_result.frame_header_len;
    assign o_frame_body_len   = head_result.frame_body_len;

    // an accepted request always leaves something to pop in the next cycle
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !empty)
        else $error("accepted request not visible on result side");

    // a size error never carries section end marks
    a_error_no_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_byte_kind == lpd_pkg::KIND_ERROR)) |-> (!o_header_end && !o_packet_end))
        else $error("size error result carries end marks");

    // decoded lengths only show on prefix or error results
    a_lengths_on_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ((o_frame_header_len != '0) || (o_frame_body_len != '0)))
        |-> ((o_byte_kind == lpd_pkg::KIND_PREFIX) || (o_byte_kind == lpd_pkg::KIND_ERROR)))
        else $error("decoded lengths on a header or body result");

    // a header byte that ends the packet also closes the header section
    a_body_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_byte_kind == lpd_pkg::KIND_HEADER) && o_packet_end) |-> o_header_end)
        else $error("packet end on header byte without header end");

endmodule
